/* sv/srecord_stream_validator_defines.svh */
// ----------------------------------------------------------------------------
// S-record stream validator assertion macros
// Concurrent checks; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SRECORD_STREAM_VALIDATOR_DEFINES_SVH
`define SRECORD_STREAM_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property p must hold at every edge outside reset
`define SRV_ASSERT(lbl, c, r, p, m) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error(m);
// condition p must never be seen outside reset
`define SRV_NEVER(lbl, c, r, p, m) \
  lbl: assert property (@(posedge c) disable iff (r) !(p)) else $error(m);
`else
`define SRV_ASSERT(lbl, c, r, p, m)
`define SRV_NEVER(lbl, c, r, p, m)
`endif

`endif

/* sv/srv_pkg.sv */
// ----------------------------------------------------------------------------
// srv_pkg
// Shared constants, item types and hex decode for the S-record validator.
// ----------------------------------------------------------------------------
package srv_pkg;

  localparam int MAX_LINE_CHARS = 248;
  localparam int TOTAL_WIDTH    = 32;
  localparam int LINE_W         = $clog2(MAX_LINE_CHARS + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TOO_LONG  = 4'd1;
  localparam logic [3:0] ST_SYNTAX    = 4'd2;
  localparam logic [3:0] ST_COUNT     = 4'd3;
  localparam logic [3:0] ST_LENGTH    = 4'd4;
  localparam logic [3:0] ST_HEX       = 4'd5;
  localparam logic [3:0] ST_CHECKSUM  = 4'd6;
  localparam logic [3:0] ST_S9_DATA   = 4'd7;
  localparam logic [3:0] ST_AFTER_S9  = 4'd8;
  localparam logic [3:0] ST_S9_FIRST  = 4'd9;
  localparam logic [3:0] ST_S1_EMPTY  = 4'd10;
  localparam logic [3:0] ST_MISSING   = 4'd11;
  localparam logic [3:0] ST_OVERFLOW  = 4'd12;

  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_LC = 8'h66;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CSUM_OK  = 8'hFF;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        is_final;
    logic        record_is_termination;
    logic [7:0]  line_data_bytes;
    logic [15:0] load_address;
    logic [31:0] total_records;
    logic [31:0] total_data_bytes;
    logic [15:0] entry_address;
  } out_item_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end else if (c >= CH_LA && c <= CH_LF_LC) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

/* sv/srv_outq.sv */
// ----------------------------------------------------------------------------
// srv_outq
// Four-entry result queue; takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module srv_outq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               wr_count,
  input  srv_pkg::out_item_t       wr0,
  input  srv_pkg::out_item_t       wr1,
  input  logic                     rd,
  output srv_pkg::out_item_t       head,
  output logic [srv_pkg::OUTQ_AW:0] level
);

  srv_pkg::out_item_t        mem [srv_pkg::OUTQ_DEPTH];
  logic [srv_pkg::OUTQ_AW-1:0] wr_ptr;
  logic [srv_pkg::OUTQ_AW-1:0] rd_ptr;
  logic [srv_pkg::OUTQ_AW-1:0] wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + 1'b1;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr_inc] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + srv_pkg::OUTQ_AW'(wr_count);
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + (srv_pkg::OUTQ_AW + 1)'(wr_count)
                     - (srv_pkg::OUTQ_AW + 1)'(rd);
    end
  end

endmodule

/* sv/srv_parser.sv */
// ----------------------------------------------------------------------------
// srv_parser
// Per-line S1/S9 record checks, stream ordering, totals and sticky status.
// ----------------------------------------------------------------------------
module srv_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  srv_pkg::in_item_t  item,
  output logic [1:0]         res_count,
  output srv_pkg::out_item_t res0,
  output srv_pkg::out_item_t res1
);

  localparam int LW    = srv_pkg::LINE_W;
  localparam int TW    = srv_pkg::TOTAL_WIDTH;
  localparam int CMP_W = (LW > 10) ? LW : 10;

  typedef struct packed {
    logic [LW-1:0] length;
    logic [LW-1:0] ret_start;
    logic [3:0]    nib;
    logic          nine;
    logic [7:0]    count;
    logic [7:0]    csum;
    logic [15:0]   addr;
    logic          header_bad;
    logic          hex_bad;
    logic          pending;
  } line_t;

  line_t         ln, ln_next, tk;
  logic          saw_data, saw_data_next;
  logic          saw_end, saw_end_next;
  logic [TW-1:0] records_seen, records_seen_next;
  logic [TW-1:0] bytes_seen, bytes_seen_next;
  logic [15:0]   start_hold, start_hold_next;
  logic          halted, halted_next;
  logic [3:0]    halt_status, halt_status_next;

  logic [7:0]    c;
  logic [4:0]    hx;
  logic [7:0]    b;
  logic [LW-1:0] len;
  logic [7:0]    data;
  logic [TW:0]   bytes_sum;
  logic [TW-1:0] rec_inc;
  logic [3:0]    fl_status;
  logic [3:0]    fin_status;
  logic          fin_ok;

  function automatic srv_pkg::out_item_t mk_res(
    input logic [3:0]    st,
    input logic          fin,
    input logic          nine,
    input logic [7:0]    dat,
    input logic [15:0]   adr,
    input logic [TW-1:0] rec,
    input logic [TW-1:0] byt,
    input logic [15:0]   sa
  );
    srv_pkg::out_item_t r;
    r.status                = st;
    r.is_final              = fin;
    r.record_is_termination = nine;
    r.line_data_bytes       = dat;
    r.load_address          = adr;
    r.total_records         = 32'(rec);
    r.total_data_bytes      = 32'(byt);
    r.entry_address         = sa;
    return r;
  endfunction

  assign c  = item.in_char;
  assign hx = srv_pkg::hex_decode(c);
  assign b  = {ln.nib, hx[3:0]};

  // ---- end-of-line checks on the current line ----
  assign len       = ln.pending ? ln.ret_start : ln.length;
  assign data      = ln.count - 8'd3;
  assign bytes_sum = {1'b0, bytes_seen} + (TW + 1)'(data);
  assign rec_inc   = (records_seen == '1) ? records_seen : records_seen + 1'b1;

  always_comb begin
    fl_status = srv_pkg::ST_OK;
    if (saw_end) begin
      fl_status = srv_pkg::ST_AFTER_S9;
    end else if (ln.header_bad || len < LW'(4)) begin
      fl_status = srv_pkg::ST_SYNTAX;
    end else if (ln.count < 8'd3) begin
      fl_status = srv_pkg::ST_COUNT;
    end else if (CMP_W'(len) != CMP_W'(4) + CMP_W'({ln.count, 1'b0})) begin
      fl_status = srv_pkg::ST_LENGTH;
    end else if (ln.hex_bad) begin
      fl_status = srv_pkg::ST_HEX;
    end else if (ln.csum != srv_pkg::CSUM_OK) begin
      fl_status = srv_pkg::ST_CHECKSUM;
    end else if (ln.nine && data != 8'd0) begin
      fl_status = srv_pkg::ST_S9_DATA;
    end else if (ln.nine && !saw_data) begin
      fl_status = srv_pkg::ST_S9_FIRST;
    end else if (!ln.nine && data == 8'd0) begin
      fl_status = srv_pkg::ST_S1_EMPTY;
    end else if (bytes_sum[TW]) begin
      fl_status = srv_pkg::ST_OVERFLOW;
    end
  end

  // ---- ordinary character into the current line ----
  always_comb begin
    tk = ln;
    if (ln.pending) begin
      // CR run followed by more text: the CR counts as a bad character
      if (ln.ret_start < LW'(4)) begin
        tk.header_bad = 1'b1;
      end else begin
        tk.hex_bad = 1'b1;
      end
      tk.pending = 1'b0;
    end
    if (ln.length == LW'(0)) begin
      if (c != srv_pkg::CH_S) tk.header_bad = 1'b1;
    end else if (ln.length == LW'(1)) begin
      if (c == srv_pkg::CH_NINE) begin
        tk.nine = 1'b1;
      end else if (c != srv_pkg::CH_ONE) begin
        tk.header_bad = 1'b1;
      end
    end else if (ln.length == LW'(2)) begin
      if (!hx[4]) tk.header_bad = 1'b1;
      else        tk.nib = hx[3:0];
    end else if (ln.length == LW'(3)) begin
      if (!hx[4]) begin
        tk.header_bad = 1'b1;
      end else begin
        tk.count = b;
        tk.csum  = b;
      end
    end else if (!hx[4]) begin
      tk.hex_bad = 1'b1;
    end else if (!ln.length[0]) begin
      tk.nib = hx[3:0];
    end else begin
      tk.csum = ln.csum + b;
      // first two bytes after the count form the address
      if (ln.length < LW'(8)) tk.addr = {ln.addr[7:0], b};
    end
    tk.length = ln.length + 1'b1;
  end

  // ---- next state and results ----
  always_comb begin
    ln_next           = ln;
    saw_data_next     = saw_data;
    saw_end_next      = saw_end;
    records_seen_next = records_seen;
    bytes_seen_next   = bytes_seen;
    start_hold_next   = start_hold;
    halted_next       = halted;
    halt_status_next  = halt_status;
    res_count         = 2'd0;
    res0              = '0;
    res1              = '0;
    fin_ok            = 1'b1;
    fin_status        = halt_status;

    if (item.end_of_stream) begin
      ln_next = '0;
      if (!halted) begin
        if (ln.length != LW'(0)) begin
          res_count = 2'd1;
          if (fl_status != srv_pkg::ST_OK) begin
            fin_ok = 1'b0;
            fin_status = fl_status;
            res0 = mk_res(fl_status, 1'b0, 1'b0, 8'd0, 16'd0,
                          records_seen, bytes_seen, start_hold);
          end else begin
            records_seen_next = rec_inc;
            bytes_seen_next   = bytes_sum[TW-1:0];
            if (ln.nine) begin
              saw_end_next    = 1'b1;
              start_hold_next = ln.addr;
            end else begin
              saw_data_next = 1'b1;
            end
            res0 = mk_res(srv_pkg::ST_OK, 1'b0, ln.nine, data, ln.addr,
                          rec_inc, bytes_sum[TW-1:0], start_hold_next);
          end
        end
        if (fin_ok) begin
          if (records_seen_next == '0 || !saw_data_next || !saw_end_next) begin
            fin_status = srv_pkg::ST_MISSING;
          end else begin
            fin_status = srv_pkg::ST_OK;
          end
        end
        halted_next      = 1'b1;
        halt_status_next = fin_status;
      end
      if (res_count == 2'd0) begin
        res0 = mk_res(fin_status, 1'b1, 1'b0, 8'd0, 16'd0,
                      records_seen_next, bytes_seen_next, start_hold_next);
        res_count = 2'd1;
      end else begin
        res1 = mk_res(fin_status, 1'b1, 1'b0, 8'd0, 16'd0,
                      records_seen_next, bytes_seen_next, start_hold_next);
        res_count = 2'd2;
      end
    end else if (!halted) begin
      if (ln.length >= LW'(srv_pkg::MAX_LINE_CHARS) && c != srv_pkg::CH_LF) begin
        halted_next      = 1'b1;
        halt_status_next = srv_pkg::ST_TOO_LONG;
        ln_next          = '0;
        res_count        = 2'd1;
        res0 = mk_res(srv_pkg::ST_TOO_LONG, 1'b0, 1'b0, 8'd0, 16'd0,
                      records_seen, bytes_seen, start_hold);
      end else if (c == srv_pkg::CH_LF) begin
        ln_next   = '0;
        res_count = 2'd1;
        if (fl_status != srv_pkg::ST_OK) begin
          halted_next      = 1'b1;
          halt_status_next = fl_status;
          res0 = mk_res(fl_status, 1'b0, 1'b0, 8'd0, 16'd0,
                        records_seen, bytes_seen, start_hold);
        end else begin
          records_seen_next = rec_inc;
          bytes_seen_next   = bytes_sum[TW-1:0];
          if (ln.nine) begin
            saw_end_next    = 1'b1;
            start_hold_next = ln.addr;
          end else begin
            saw_data_next = 1'b1;
          end
          res0 = mk_res(srv_pkg::ST_OK, 1'b0, ln.nine, data, ln.addr,
                        rec_inc, bytes_sum[TW-1:0], start_hold_next);
        end
      end else if (c == srv_pkg::CH_CR) begin
        if (!ln.pending) begin
          ln_next.pending   = 1'b1;
          ln_next.ret_start = ln.length;
        end
        ln_next.length = ln.length + 1'b1;
      end else begin
        ln_next = tk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ln           <= '0;
      saw_data     <= 1'b0;
      saw_end      <= 1'b0;
      records_seen <= '0;
      bytes_seen   <= '0;
      start_hold   <= '0;
      halted       <= 1'b0;
      halt_status  <= srv_pkg::ST_OK;
    end else if (take) begin
      ln           <= ln_next;
      saw_data     <= saw_data_next;
      saw_end      <= saw_end_next;
      records_seen <= records_seen_next;
      bytes_seen   <= bytes_seen_next;
      start_hold   <= start_hold_next;
      halted       <= halted_next;
      halt_status  <= halt_status_next;
    end
  end

endmodule

/* sv/srecord_stream_validator.sv */
// ----------------------------------------------------------------------------
// srecord_stream_validator
// Path: an accepted character is held in the input register; the parser then writes its result into the result queue.
// Throughput: one character per cycle; the parser takes the input register
// whenever the four-entry result queue has room for two items.
// Reset (rst, synchronous): clears line state, totals, sticky status and queue.
// ----------------------------------------------------------------------------
`include "srecord_stream_validator_defines.svh"

module srecord_stream_validator (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  srv_pkg::in_item_t  char_item,
  output logic               res_valid,
  input  logic               res_stall,
  output srv_pkg::out_item_t res_item
);

  logic                      in_valid_q;
  srv_pkg::in_item_t         in_q;
  logic                      take;
  logic [1:0]                res_count;
  srv_pkg::out_item_t        res0;
  srv_pkg::out_item_t        res1;
  logic [srv_pkg::OUTQ_AW:0] level;
  logic                      pop;

  // room for the worst case of two results from one item
  assign take       = in_valid_q &&
                      (level <= (srv_pkg::OUTQ_AW + 1)'(srv_pkg::OUTQ_DEPTH - 2));
  assign char_stall = in_valid_q && !take;
  assign res_valid  = (level != '0);
  assign pop        = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!char_stall) begin
      in_valid_q <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      in_q <= char_item;
    end
  end

  srv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_q),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  srv_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_count (take ? res_count : 2'd0),
    .wr0      (res0),
    .wr1      (res1),
    .rd       (pop),
    .head     (res_item),
    .level    (level)
  );

  `SRV_NEVER(a_queue_over, clk, rst, level > (srv_pkg::OUTQ_AW + 1)'(srv_pkg::OUTQ_DEPTH), "result queue overfilled")
  `SRV_ASSERT(a_stall_held, clk, rst, char_stall |-> in_valid_q, "stall without a held item")
  `SRV_ASSERT(a_eos_result, clk, rst, (take && in_q.end_of_stream) |=> (level != '0), "end of stream gave no summary")

endmodule
